>>> src/qn_pkg.sv
// Shared constants, types and codes for the quantile normalizer.
// No dependencies; every other file in src imports this package.
`default_nettype none

package qn_pkg;

    // Storage sizes and field widths
    localparam int MAX_SAMPLES = 64;
    localparam int VALUE_BITS  = 32;
    localparam int POS_W       = 6;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int IN_DATA_W   = ((POS_W + VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((VALUE_BITS + POS_W + 7) / 8) * 8;

    // Item kinds carried on the input tuser bit
    localparam logic MODE_REF    = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [CNT_W-1:0]             t_count;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RANK,
        ST_LOOK,
        ST_CALC,
        ST_OUT
    } t_state;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic clear;
        logic rank;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> src/quantile_normalize_to_reference_top.sv
// Top level of the quantile normalizer: handshake control, the ranking
// cell chain and the reference lookup. Depends on qn_pkg, qn_cell, qn_lookup.
//
//  port group     dir  payload
//  i_s_axis_*     in   tdata {item_value, ref_position}, tuser mode, tlast final_sample
//  o_m_axis_*     out  tdata {sample_position, normalized_value}, tlast last_result
//
// While loading, a reference write or a sample is accepted whenever tvalid is high.
// A final sample starts ranking: the cell ring rotates once, then each result
// goes through a table read, the average and the present step (ST_LOOK, ST_CALC,
// ST_OUT), plus any time the output side holds tready low.
// Input tready is low from the final sample until the last result is taken.
// Reset clears the sample count, the state and the cell valid flags; the
// reference table holds no defined value until written.
`default_nettype none

module quantile_normalize_to_reference_top
    import qn_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // [5:0] ref_position, [37:6] item_value
    input  wire logic                  i_s_axis_tuser,  // [0] mode
    input  wire logic                  i_s_axis_tlast,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,  // [31:0] normalized_value, [37:32] sample_position
    output logic                       o_m_axis_tlast
);

    t_state           r_state;
    t_state           n_state;
    t_count           r_count;
    t_count           r_left;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_rank_cnt;
    logic             r_ovalid;
    t_value           r_out_val;
    logic [IDX_W-1:0] r_out_pos;
    logic             r_out_last;
    t_cell_ctl        w_ctl;
    logic             w_accept;
    logic             w_is_sample;
    logic             w_store;
    logic             w_ref_wr;
    logic [POS_W-1:0] w_in_pos;
    t_value           w_in_val;
    t_value           w_result;

    t_value w_mov_val [MAX_SAMPLES];
    logic   w_mov_vld [MAX_SAMPLES];
    t_count w_gt      [MAX_SAMPLES];
    t_count w_eq      [MAX_SAMPLES];

    // Unpack the input word
    always_comb begin
        w_in_pos    = i_s_axis_tdata[POS_W-1:0];
        w_in_val    = i_s_axis_tdata[POS_W +: VALUE_BITS];
        w_accept    = i_s_axis_tvalid && o_s_axis_tready;
        w_is_sample = (i_s_axis_tuser == MODE_SAMPLE);
        w_store     = w_accept && w_is_sample && (r_count < t_count'(MAX_SAMPLES));
        w_ref_wr    = w_accept && (i_s_axis_tuser == MODE_REF)
                      && ({1'b0, w_in_pos} < (POS_W + 1)'(MAX_SAMPLES));
    end

    // Next state and chain control
    always_comb begin
        n_state         = r_state;
        w_ctl           = '0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_s_axis_tready = 1'b1;
                if (w_accept && w_is_sample && i_s_axis_tlast) begin
                    n_state = ST_RANK;
                end
            end
            ST_RANK: begin
                w_ctl.rank = 1'b1;
                if (r_rank_cnt == IDX_W'(MAX_SAMPLES - 1)) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_m_axis_tready) begin
                    w_ctl.shift = 1'b1;
                    if (r_left == t_count'(1)) begin
                        w_ctl.clear = 1'b1;
                        n_state     = ST_LOAD;
                    end else begin
                        n_state = ST_LOOK;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Sample count, result count and ranking counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_left     <= '0;
            r_pos      <= '0;
            r_rank_cnt <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_state == ST_LOAD && w_accept && w_is_sample) begin
                if (i_s_axis_tlast) begin
                    r_count <= '0;
                    r_left  <= r_count + t_count'(w_store);
                    r_pos   <= '0;
                end else if (w_store) begin
                    r_count <= r_count + t_count'(1);
                end
            end
            if (r_state == ST_RANK) begin
                r_rank_cnt <= r_rank_cnt + IDX_W'(1);
            end else begin
                r_rank_cnt <= '0;
            end
            if (r_state == ST_CALC) begin
                r_ovalid <= 1'b1;
            end else if (w_ctl.shift) begin
                r_ovalid <= 1'b0;
                r_left   <= r_left - t_count'(1);
                r_pos    <= r_pos + IDX_W'(1);
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC) begin
            r_out_val  <= w_result;
            r_out_pos  <= r_pos;
            r_out_last <= (r_left == t_count'(1));
        end
    end

    // Ranking ring: value moves up, counts move down toward cell zero
    for (genvar c = 0; c < MAX_SAMPLES; c++) begin : g_cell
        localparam int PREV = (c + MAX_SAMPLES - 1) % MAX_SAMPLES;
        t_count w_next_gt;
        t_count w_next_eq;

        if (c == MAX_SAMPLES - 1) begin : g_end
            assign w_next_gt = '0;
            assign w_next_eq = '0;
        end else begin : g_mid
            assign w_next_gt = w_gt[c+1];
            assign w_next_eq = w_eq[c+1];
        end

        qn_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_wr       (w_store && (r_count[IDX_W-1:0] == IDX_W'(c))),
            .i_value    (w_in_val),
            .i_prev_val (w_mov_val[PREV]),
            .i_prev_vld (w_mov_vld[PREV]),
            .i_next_gt  (w_next_gt),
            .i_next_eq  (w_next_eq),
            .o_mov_val  (w_mov_val[c]),
            .o_mov_vld  (w_mov_vld[c]),
            .o_gt       (w_gt[c]),
            .o_eq       (w_eq[c])
        );
    end

    qn_lookup u_lookup (
        .i_clk     (i_clk),
        .i_wr_en   (w_ref_wr),
        .i_wr_addr (w_in_pos[IDX_W-1:0]),
        .i_wr_data (w_in_val),
        .i_gt      (w_gt[0]),
        .i_eq      (w_eq[0]),
        .o_result  (w_result)
    );

    // Pack the output word
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {(OUT_DATA_W - VALUE_BITS - POS_W)'(0),
                              POS_W'(r_out_pos), r_out_val};

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(MAX_SAMPLES))
        else $error("sample count beyond storage");

    a_out_has_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_left != '0))
        else $error("result shown with no result pending");

    a_rank_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RANK && r_rank_cnt == IDX_W'(MAX_SAMPLES - 1)) |=>
        (r_state == ST_LOOK))
        else $error("ranking did not end after one full rotation");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=>
        (r_state == ST_LOAD && r_count == '0))
        else $error("last result did not return to loading");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |-> !o_m_axis_tvalid)
        else $error("input taken while a result is pending");
`endif

endmodule

`default_nettype wire

>>> src/qn_cell.sv
// One cell of the ranking chain: holds one sample, a circulating value
// and its greater/equal counts. Depends on qn_pkg.
`default_nettype none

module qn_cell
    import qn_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_wr,
    input  wire t_value    i_value,
    input  wire t_value    i_prev_val,
    input  wire logic      i_prev_vld,
    input  wire t_count    i_next_gt,
    input  wire t_count    i_next_eq,
    output t_value         o_mov_val,
    output logic           o_mov_vld,
    output t_count         o_gt,
    output t_count         o_eq
);

    t_value r_own;
    t_value r_mov;
    logic   r_mov_vld;
    t_count r_gt;
    t_count r_eq;
    logic   w_gt_hit;
    logic   w_eq_hit;

    // Compare the passing value against the held sample
    always_comb begin
        w_gt_hit = r_mov_vld && (r_mov > r_own);
        w_eq_hit = r_mov_vld && (r_mov == r_own);
    end

    // Valid flag of the circulating value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mov_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_mov_vld <= 1'b0;
        end else if (i_wr) begin
            r_mov_vld <= 1'b1;
        end else if (i_ctl.rank) begin
            r_mov_vld <= i_prev_vld;
        end
    end

    // Load the sample, rotate and count, or hand counts toward cell zero
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_own <= i_value;
            r_mov <= i_value;
            r_gt  <= '0;
            r_eq  <= '0;
        end else if (i_ctl.rank) begin
            r_mov <= i_prev_val;
            r_gt  <= r_gt + t_count'(w_gt_hit);
            r_eq  <= r_eq + t_count'(w_eq_hit);
        end else if (i_ctl.shift) begin
            r_gt <= i_next_gt;
            r_eq <= i_next_eq;
        end
    end

    assign o_mov_val = r_mov;
    assign o_mov_vld = r_mov_vld;
    assign o_gt      = r_gt;
    assign o_eq      = r_eq;

endmodule

`default_nettype wire

>>> src/qn_lookup.sv
// Reference table with two registered read ports and the tie averaging.
// Depends on qn_pkg.
`default_nettype none

module qn_lookup
    import qn_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  wire t_value           i_wr_data,
    input  wire t_count           i_gt,
    input  wire t_count           i_eq,
    output t_value                o_result
);

    t_value             r_table [MAX_SAMPLES];
    t_value             r_rd_a;
    t_value             r_rd_b;
    logic               r_odd;
    t_count             w_mid;
    logic [IDX_W-1:0]   w_addr_a;
    logic [IDX_W-1:0]   w_addr_b;
    logic [VALUE_BITS:0] w_sum;

    // Upper entry is g + e/2; for an even tie the lower one sits just before it
    always_comb begin
        w_mid    = i_gt + (i_eq >> 1);
        w_addr_b = w_mid[IDX_W-1:0];
        w_addr_a = i_eq[0] ? w_addr_b : w_addr_b - IDX_W'(1);
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_table[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read ports
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_table[w_addr_a];
        r_rd_b <= r_table[w_addr_b];
        r_odd  <= i_eq[0];
    end

    // Floor of the mean over a sign-extended sum
    always_comb begin
        w_sum    = {r_rd_a[VALUE_BITS-1], r_rd_a} + {r_rd_b[VALUE_BITS-1], r_rd_b};
        o_result = r_odd ? r_rd_a : t_value'(w_sum[VALUE_BITS:1]);
    end

endmodule

`default_nettype wire

>>> dv/quantile_normalize_to_reference_top_test.sv
// Self-checking testbench for quantile_normalize_to_reference_top: a directed table, then
// random reference writes and sample vectors, with each result word checked by a local ranker.
// Depends on qn_pkg and the RTL in src; reads no files.
`default_nettype none

module quantile_normalize_to_reference_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qn_pkg::*;

    localparam int ITEM_GOAL      = 230;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int MAX_GAP        = 11;

    // One input word plus an optional hand-computed value for its vector
    typedef struct {
        logic             mode;
        logic [POS_W-1:0] pos;
        t_value           val;
        logic             fin;
        logic             typed;
        t_value           typed_val;
    } t_stim;

    // One normalized result word
    typedef struct {
        t_value           val;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_norm;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;   // [5:0] ref_position, [37:6] item_value
    logic                  i_s_axis_tuser = 1'b0; // [0] mode
    logic                  i_s_axis_tlast = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;        // [31:0] normalized_value, [37:32] sample_position
    logic                  o_m_axis_tlast;

    // Local copy of the block state
    t_value ref_dist [MAX_SAMPLES];
    t_value smp_buf [MAX_SAMPLES];
    int     smp_cnt = 0;

    t_norm  norm_q[$];
    t_stim  dir_tab[$];
    t_norm  got_word;
    t_norm  want_word;
    int     errors = 0;
    int     items_sent = 0;
    int     idle_cycles = 0;
    logic   calm = 1'b0;

    quantile_normalize_to_reference_top dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h (at %0t)", what, got, want, $realtime);
        errors++;
    endtask

    function automatic t_stim mk(input logic mode, input logic [POS_W-1:0] pos,
                                 input t_value val, input logic fin,
                                 input logic typed = 1'b0, input t_value typed_val = '0);
        t_stim s;
        s.mode = mode;
        s.pos = pos;
        s.val = val;
        s.fin = fin;
        s.typed = typed;
        s.typed_val = typed_val;
        return s;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input t_stim s);
        dir_tab = {dir_tab, s};
    endfunction

    // Update the local state with an accepted word; a final sample ranks the
    // stored vector and queues one normalized word per sample.
    function automatic void absorb_word(input t_stim s);
        int gt;
        int eq;
        int k;
        t_norm r;
        logic [VALUE_BITS:0] pair_sum;
        if (s.mode == MODE_REF) begin
            ref_dist[s.pos] = s.val;
            return;
        end
        if (smp_cnt < MAX_SAMPLES) begin
            smp_buf[smp_cnt] = s.val;
            smp_cnt++;
        end
        if (!s.fin)
            return;
        for (int i = 0; i < smp_cnt; i++) begin
            gt = 0;
            eq = 0;
            for (int j = 0; j < smp_cnt; j++) begin
                if (smp_buf[j] > smp_buf[i])
                    gt++;
                else if (smp_buf[j] == smp_buf[i])
                    eq++;
            end
            if (eq % 2 == 1) begin
                r.val = ref_dist[gt + (eq - 1) / 2];
            end else begin
                // floor of the mean: sign-extend, add, drop the low bit
                k = gt + eq / 2;
                pair_sum = {ref_dist[k-1][VALUE_BITS-1], ref_dist[k-1]}
                         + {ref_dist[k][VALUE_BITS-1], ref_dist[k]};
                r.val = pair_sum[VALUE_BITS:1];
            end
            if (s.typed)
                r.val = s.typed_val;
            r.pos = POS_W'(i);
            r.last = (i == smp_cnt - 1);
            norm_q = {norm_q, r};
        end
        smp_cnt = 0;
    endfunction

    // Present one word after a random gap and hold it until accepted
    task automatic send_word(input t_stim s);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_DATA_W - POS_W - VALUE_BITS){1'b0}}, s.val, s.pos};
        i_s_axis_tuser  <= s.mode;
        i_s_axis_tlast  <= s.fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
        absorb_word(s);
        items_sent++;
    endtask

    // Tie-prone small values, extremes, or anything
    function automatic t_value pick_sample();
        int d;
        d = $urandom_range(0, 6);
        case ($urandom_range(0, 3))
            0: return t_value'((d - 3) * 65536);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return t_value'($urandom);
        endcase
    endfunction

    function automatic t_value pick_ref();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return t_value'($urandom);
    endfunction

    // Drain results with random stalls
    initial begin : drain
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_word.val  = o_m_axis_tdata[VALUE_BITS-1:0];
            got_word.pos  = o_m_axis_tdata[VALUE_BITS+POS_W-1:VALUE_BITS];
            got_word.last = o_m_axis_tlast;
            if (norm_q.size() == 0) begin
                report("result with nothing pending", 64'(got_word.val), '0);
            end else begin
                want_word = norm_q.pop_front();
                if (got_word.val !== want_word.val)
                    report("normalized_value", 64'(got_word.val), 64'(want_word.val));
                if (got_word.pos !== want_word.pos)
                    report("sample_position", 64'(got_word.pos), 64'(want_word.pos));
                if (got_word.last !== want_word.last)
                    report("last_result", 64'(got_word.last), 64'(want_word.last));
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int len;
        int vec;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: reference extremes, tie handling, ignored flags
        add_row(mk(MODE_REF, 6'd0,  32'h7FFF_FFFF, 1'b0));
        add_row(mk(MODE_REF, 6'd1,  32'h8000_0000, 1'b0));
        add_row(mk(MODE_REF, 6'd2,  32'h0001_0000, 1'b0));
        add_row(mk(MODE_REF, 6'd3,  32'hFFFF_0000, 1'b0));
        // final flag on a table write makes no result
        add_row(mk(MODE_REF, 6'd63, 32'h55AA_0000, 1'b1));
        add_row(mk(MODE_REF, 6'd4,  32'h0000_8000, 1'b0));
        // lone sample takes the top entry
        add_row(mk(MODE_SAMPLE, 6'd0, 32'h1234_5678, 1'b1, 1'b1, 32'h7FFF_FFFF));
        // two equal samples average the two top entries, rounding down
        add_row(mk(MODE_SAMPLE, 6'd0, 32'h8000_0000, 1'b0));
        add_row(mk(MODE_SAMPLE, 6'd0, 32'h8000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF));
        // three equal samples take the middle entry
        add_row(mk(MODE_SAMPLE, 6'd63, 32'h7FFF_FFFF, 1'b0));
        add_row(mk(MODE_SAMPLE, 6'd63, 32'h7FFF_FFFF, 1'b0));
        add_row(mk(MODE_SAMPLE, 6'd63, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h8000_0000));
        add_row(mk(MODE_SAMPLE, 6'd21, 32'h7FFF_FFFF, 1'b0));
        add_row(mk(MODE_SAMPLE, 6'd42, 32'h8000_0000, 1'b1));
        // table write in the middle of a vector, with the final flag set
        add_row(mk(MODE_SAMPLE, 6'h3F, 32'h0000_0005, 1'b0));
        add_row(mk(MODE_REF, 6'd3,  32'h7FFF_0000, 1'b1));
        add_row(mk(MODE_SAMPLE, 6'd0, 32'h0000_0005, 1'b0));
        add_row(mk(MODE_SAMPLE, 6'd0, 32'hFFFF_FFFD, 1'b0));
        add_row(mk(MODE_SAMPLE, 6'd0, 32'h0000_0009, 1'b1));
        add_row(mk(MODE_SAMPLE, 6'd0, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF));
        // four equal samples average entries one and two
        add_row(mk(MODE_SAMPLE, 6'd0, 32'hFFFF_FFFF, 1'b0));
        add_row(mk(MODE_SAMPLE, 6'd0, 32'hFFFF_FFFF, 1'b0));
        add_row(mk(MODE_SAMPLE, 6'd0, 32'hFFFF_FFFF, 1'b0));
        add_row(mk(MODE_SAMPLE, 6'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hC000_8000));
        foreach (dir_tab[r])
            send_word(dir_tab[r]);

        // Fill the whole table first so any vector length reads written entries
        for (int p = 0; p < MAX_SAMPLES; p++)
            send_word(mk(MODE_REF, POS_W'(p), pick_ref(), 1'(($urandom_range(0, 1)))));

        // Random vectors; one overruns the sample store
        vec = 0;
        while (items_sent < ITEM_GOAL) begin
            calm = ($urandom_range(0, 4) == 0);
            len = (vec == 3) ? MAX_SAMPLES + $urandom_range(1, 3) : $urandom_range(1, 6);
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(mk(MODE_REF, POS_W'($urandom_range(0, 63)), pick_ref(),
                                 1'($urandom_range(0, 1))));
                send_word(mk(MODE_SAMPLE, POS_W'($urandom_range(0, 63)), pick_sample(),
                             (j == len - 1)));
            end
            vec++;
        end
        calm = 1'b0;
        i_s_axis_tvalid <= 1'b0;

        // Wait for the remaining results, then let the block settle
        while (norm_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
src/qn_pkg.sv
src/qn_cell.sv
src/qn_lookup.sv
src/quantile_normalize_to_reference_top.sv
dv/quantile_normalize_to_reference_top_test.sv
